// File: rtl/qesm_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter package
// Shared widths, register indexes, word types and the sequencer states.
// ----------------------------------------------------------------------------
package qesm_pkg;

  // Width of the per-wheel signed edge counter.
  localparam int COUNT_BITS = 32;
  // Width of the stored edge stamps and of the measured period.
  localparam int STAMP_BITS = 17;

  localparam int GAIN_BITS    = 32;
  localparam int MODULUS_BITS = 17;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(10000);

  // Divider: one quotient bit per step over the whole gain word.
  localparam int DIV_STEPS    = GAIN_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_GAIN    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMER_MODULUS = CFG_IDX_BITS'(1);

  localparam logic signed [31:0] SPEED_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SPEED_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        wheel;
    logic        phase_a;
    logic        phase_b;
    logic [15:0] stamp_us;
  } in_word_t;

  typedef struct packed {
    logic               which_wheel;
    logic signed [31:0] position_count;
    logic               moving_forward;
    logic [16:0]        period_us;
    logic signed [31:0] angular_speed;
    logic               speed_saturated;
  } out_word_t;

  // Status returned by the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: rtl/quadrature_edge_speed_meter.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter
// Two-wheel encoder edge counter with period-based signed speed.
// ----------------------------------------------------------------------------
// Each input word is one A-phase edge of one wheel: wheel id, A and B levels
// and a microsecond timestamp. Each accepted word yields exactly one output
// word with the updated signed edge count, the direction, the period since
// that wheel's previous edge and the speed, gain divided by period.
// Channels use valid/stall: a word moves on a clock edge with valid high and
// stall low. Configuration writes use cfg_valid/cfg_ready; cfg_ready is
// always high. Index 0 is speed_gain, index 1 is timer_modulus; other
// indexes are ignored. Write configuration only while the block is idle.
// One word is worked on at a time: a new word is accepted only after the last
// one has loaded the output register. The shared restoring divider produces
// one quotient bit per clock over the 32-bit gain. After the divider registers
// its last quotient bit and its done flag, the sequencer moves to ST_OUT and
// loads the output register from there once that register is free.
// While a word is being worked on, in_stall is high. If the receiver stalls,
// the finished word waits in the output register and the next input word is
// still accepted and computed; it waits before loading the output register.
// Synchronous reset clears the counts, the stored stamps, speed_gain to zero
// and timer_modulus to 10000.
module quadrature_edge_speed_meter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  qesm_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output qesm_pkg::out_word_t                  out_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qesm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [qesm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import qesm_pkg::*;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [GAIN_BITS-1:0]    gain_r;
  logic [MODULUS_BITS-1:0] modulus_r;

  // Per-wheel state.
  logic [COUNT_BITS-1:0] edge_cnt_r [2];
  logic [STAMP_BITS-1:0] last_stamp_r [2];

  // The word in flight.
  logic                  wheel_r;
  logic                  fwd_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [STAMP_BITS-1:0] period_r;

  out_word_t out_word_r, out_word_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic                  in_accept;
  logic                  fwd;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [STAMP_BITS-1:0] t0, t1, period_nxt;
  logic                  out_free;
  logic                  load_out;

  logic [GAIN_BITS-1:0] quotient;
  div_status_t          div_status;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Left wheel counts up when A differs from B; the right wheel is mirrored.
  assign fwd = in_word.wheel ? (in_word.phase_a == in_word.phase_b)
                             : (in_word.phase_a != in_word.phase_b);

  assign count_nxt = fwd ? edge_cnt_r[in_word.wheel] + COUNT_BITS'(1)
                         : edge_cnt_r[in_word.wheel] - COUNT_BITS'(1);

  // Period on the wrapping timer; arithmetic wraps at the stamp width.
  assign t0 = last_stamp_r[in_word.wheel];
  assign t1 = STAMP_BITS'(in_word.stamp_us);
  assign period_nxt = (t1 < t0) ? (STAMP_BITS'(modulus_r) - t0 + t1) : (t1 - t0);

  qesm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .dividend (gain_r),
    .divisor  (period_nxt),
    .quotient (quotient),
    .status   (div_status)
  );

  // Sequencer and output word assembly.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    load_out      = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt               = 1'b1;
      out_word_nxt.which_wheel    = wheel_r;
      out_word_nxt.position_count = 32'(signed'(count_r));
      out_word_nxt.moving_forward = fwd_r;
      out_word_nxt.period_us      = 17'(period_r);
      if (period_r == '0) begin
        // A zero period pins the speed to full scale in the edge direction.
        out_word_nxt.angular_speed   = fwd_r ? SPEED_MAX : SPEED_MIN;
        out_word_nxt.speed_saturated = 1'b1;
      end else if (fwd_r) begin
        out_word_nxt.angular_speed   = quotient[31] ? SPEED_MAX : signed'(quotient);
        out_word_nxt.speed_saturated = quotient[31];
      end else if (quotient[31] && (|quotient[30:0])) begin
        out_word_nxt.angular_speed   = SPEED_MIN;
        out_word_nxt.speed_saturated = 1'b1;
      end else begin
        out_word_nxt.angular_speed   = signed'(32'(0) - quotient);
        out_word_nxt.speed_saturated = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (in_accept) begin
      wheel_r  <= in_word.wheel;
      fwd_r    <= fwd;
      count_r  <= count_nxt;
      period_r <= period_nxt;
    end
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      gain_r          <= '0;
      modulus_r       <= MODULUS_RESET;
      edge_cnt_r[0]   <= '0;
      edge_cnt_r[1]   <= '0;
      last_stamp_r[0] <= '0;
      last_stamp_r[1] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SPEED_GAIN) begin
          gain_r <= cfg_data[GAIN_BITS-1:0];
        end else if (cfg_index == REG_TIMER_MODULUS) begin
          modulus_r <= cfg_data[MODULUS_BITS-1:0];
        end
      end
      if (in_accept) begin
        edge_cnt_r[in_word.wheel]   <= count_nxt;
        last_stamp_r[in_word.wheel] <= t1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The divider reports completion only for the word the sequencer waits on.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // An accepted word always starts the divider.
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (div_status.busy && (state_r == ST_DIV)))
    else $error("accepted word did not start the divider");

  // A zero period must always be flagged as saturated.
  a_zero_period_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.period_us == '0)) |-> out_word_r.speed_saturated)
    else $error("zero period without saturation flag");

  // Forward edges never give a negative speed.
  a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.moving_forward) |-> !out_word_r.angular_speed[31])
    else $error("forward edge with negative speed");

  // The output register is only loaded when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("output word overwritten while stalled");

endmodule

// File: rtl/qesm_divider.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter divider
// Restoring radix-2 divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module qesm_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [qesm_pkg::GAIN_BITS-1:0]      dividend,
  input  logic [qesm_pkg::STAMP_BITS-1:0]     divisor,
  output logic [qesm_pkg::GAIN_BITS-1:0]      quotient,
  output qesm_pkg::div_status_t               status
);
  import qesm_pkg::*;

  logic [STAMP_BITS-1:0]   rem_r, rem_nxt;
  logic [GAIN_BITS-1:0]    quo_r, quo_nxt;
  logic [STAMP_BITS-1:0]   dvs_r, dvs_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [STAMP_BITS:0]     trial;
  logic [STAMP_BITS:0]     diff;

  // The dividend shifts out of the top of quo_r while quotient bits shift in.
  assign trial = {rem_r, quo_r[GAIN_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_BITS'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[STAMP_BITS-1:0];
        quo_nxt = {quo_r[GAIN_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[STAMP_BITS-1:0];
        quo_nxt = {quo_r[GAIN_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_BITS'(1);
      if (cnt_r == DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature edge speed meter testbench
// Drives encoder edge words and register writes, and checks every result
// word against a behavioral predictor of counts, periods and speeds.
// ----------------------------------------------------------------------------
// A short table of directed rows comes first. It covers the first edge after
// reset, zero periods, timer wrap, gain extremes and the two quotient limits,
// out-of-range moduli and writes to unknown indexes. A few of its results are
// typed in by hand. After that, random phases under different register
// settings send timestamp sequences that mostly advance like a real timer.
// Both channels idle at random, and one phase holds the receiver off long
// enough that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import qesm_pkg::*;

  localparam int ITEMS_PER_PHASE = 210;
  localparam int PHASE_COUNT     = 6;
  localparam int PRESSURE_PHASE  = 2;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int TIMEOUT_NS      = 3_000_000;

  // Indexes that decode to no register; writes to them must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED     = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_TOP = {CFG_IDX_BITS{1'b1}};

  typedef enum logic [0:0] {
    ROW_EDGE,
    ROW_WRITE
  } row_kind_t;

  // One row of the directed table: either an edge word or a register write.
  // When by_hand is set, the result typed into the row is the one expected.
  typedef struct {
    row_kind_t                 kind;
    logic [CFG_IDX_BITS-1:0]   index;
    logic [CFG_DATA_BITS-1:0]  data;
    in_word_t                  edge_word;
    bit                        by_hand;
    out_word_t                 reading;
  } table_row_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_word_t                  in_word   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_word_t                 out_word;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // Predictor state: per-wheel counts and stamps, plus the two registers.
  logic [COUNT_BITS-1:0]     wheel_count [2];
  logic [STAMP_BITS-1:0]     wheel_stamp [2];
  logic [GAIN_BITS-1:0]      gain_setting;
  logic [MODULUS_BITS-1:0]   modulus_setting;

  // Result words owed by the block, oldest first.
  out_word_t                 pending_readings [$];
  table_row_t                directed_rows [$];
  int                        mismatches = 0;

  // Idle controls shared between the stimulus and the receiver pacing.
  bit                        tx_idle  = 1'b0;
  bit                        rx_idle  = 1'b0;
  bit                        hold_req = 1'b0;

  quadrature_edge_speed_meter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #TIMEOUT_NS;
    $display("tb: failure");
    $finish;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Register write as the block decodes it: the modulus keeps its low bits,
  // and an index that names no register changes nothing.
  function automatic void meter_configure(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_SPEED_GAIN:    gain_setting = data[GAIN_BITS-1:0];
      REG_TIMER_MODULUS: modulus_setting = data[MODULUS_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Predicts the result word of one edge and advances the per-wheel state.
  function automatic out_word_t meter_step(input in_word_t w);
    out_word_t               r;
    logic                    fwd;
    logic [STAMP_BITS-1:0]   now_stamp;
    logic [STAMP_BITS-1:0]   prev_stamp;
    logic [STAMP_BITS-1:0]   period;
    logic [GAIN_BITS-1:0]    quot;
    // Left wheel runs forward when A and B differ; the right wheel is mirrored.
    fwd = (w.phase_a ^ w.phase_b) ^ w.wheel;
    if (fwd) begin
      wheel_count[w.wheel] = wheel_count[w.wheel] + 1'b1;
    end else begin
      wheel_count[w.wheel] = wheel_count[w.wheel] - 1'b1;
    end
    // A stamp below the previous one means the timer wrapped at the modulus.
    // Nothing keeps the stamp below the modulus, so the sum may wrap too.
    now_stamp  = STAMP_BITS'(w.stamp_us);
    prev_stamp = wheel_stamp[w.wheel];
    if (now_stamp < prev_stamp) begin
      period = modulus_setting - prev_stamp + now_stamp;
    end else begin
      period = now_stamp - prev_stamp;
    end
    wheel_stamp[w.wheel] = now_stamp;

    r.which_wheel     = w.wheel;
    r.position_count  = wheel_count[w.wheel][31:0];
    r.moving_forward  = fwd;
    r.period_us       = period;
    r.speed_saturated = 1'b0;
    if (period == '0) begin
      // No time between edges: full scale in the direction of travel.
      r.speed_saturated = 1'b1;
      r.angular_speed   = fwd ? SPEED_MAX : SPEED_MIN;
    end else begin
      quot = gain_setting / GAIN_BITS'(period);
      if (fwd && quot > $unsigned(SPEED_MAX)) begin
        r.speed_saturated = 1'b1;
        r.angular_speed   = SPEED_MAX;
      end else if (!fwd && quot > $unsigned(SPEED_MIN)) begin
        r.speed_saturated = 1'b1;
        r.angular_speed   = SPEED_MIN;
      end else begin
        // Backward at exactly 2^31 negates onto itself, which is the minimum.
        r.angular_speed = fwd ? quot : -quot;
      end
    end
    return r;
  endfunction

  function automatic table_row_t edge_row(input bit wh, input bit a, input bit b,
                                          input int stamp);
    table_row_t row;
    row.kind               = ROW_EDGE;
    row.index              = '0;
    row.data               = '0;
    row.edge_word.wheel    = wh;
    row.edge_word.phase_a  = a;
    row.edge_word.phase_b  = b;
    row.edge_word.stamp_us = stamp[15:0];
    row.by_hand            = 1'b0;
    row.reading            = '0;
    return row;
  endfunction

  function automatic table_row_t known_row(input bit wh, input bit a, input bit b,
                                           input int stamp,
                                           input logic signed [31:0] count,
                                           input bit fwd, input int period,
                                           input logic signed [31:0] speed,
                                           input bit sat);
    table_row_t row;
    row = edge_row(wh, a, b, stamp);
    row.by_hand                 = 1'b1;
    row.reading.which_wheel     = wh;
    row.reading.position_count  = count;
    row.reading.moving_forward  = fwd;
    row.reading.period_us       = period[16:0];
    row.reading.angular_speed   = speed;
    row.reading.speed_saturated = sat;
    return row;
  endfunction

  function automatic table_row_t write_row(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
    table_row_t row;
    row       = edge_row(1'b0, 1'b0, 1'b0, 0);
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = data;
    return row;
  endfunction

  // Offers one edge word and returns at the clock edge that accepts it.
  // The valid stays high so that a following word can go out back to back.
  task automatic send_edge(input in_word_t w);
    int gap;
    cfg_valid <= 1'b0;
    gap = (tx_idle && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Registers change only with the block idle, so every owed result word has
  // to be in first. Each edge gives exactly one word, so an empty queue means
  // nothing is left in flight.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    meter_configure(idx, data);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: every accepted word is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result word with no edge waiting for it");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        check_field("which_wheel", 32'(want.which_wheel), 32'(out_word.which_wheel));
        check_field("position_count", want.position_count, out_word.position_count);
        check_field("moving_forward", 32'(want.moving_forward),
                    32'(out_word.moving_forward));
        check_field("period_us", 32'(want.period_us), 32'(out_word.period_us));
        check_field("angular_speed", want.angular_speed, out_word.angular_speed);
        check_field("speed_saturated", 32'(want.speed_saturated),
                    32'(out_word.speed_saturated));
      end
    end
  end

  // Receiver pacing. Random stall runs while rx_idle is set, and once, on
  // request, a long hold-off so that the input side backs up.
  initial begin : result_pacing
    int  run_left;
    bit  hold_taken;
    run_left   = 0;
    hold_taken = 1'b0;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        run_left   = PRESSURE_CYCLES;
      end else if (run_left == 0 && rx_idle && $urandom_range(0, 99) < 10) begin
        run_left = idle_len();
      end
      if (run_left > 0) begin
        out_stall <= 1'b1;
        run_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    table_row_t               row;
    in_word_t                 w;
    out_word_t                predicted;
    logic [GAIN_BITS-1:0]     gain;
    logic [CFG_DATA_BITS-1:0] modulus_data;
    int                       modulus;
    int                       timer_now;
    int                       pick;
    int                       step;
    bit                       modulus_sane;

    wheel_count[0]  = '0;
    wheel_count[1]  = '0;
    wheel_stamp[0]  = '0;
    wheel_stamp[1]  = '0;
    gain_setting    = '0;
    modulus_setting = MODULUS_RESET;
    timer_now       = 0;

    // Reset defaults: gain zero, so speeds are zero unless the period is.
    // The very first edge measures its period from a stored stamp of zero.
    directed_rows.push_back(known_row(0, 1, 0, 0, 1, 1, 0, SPEED_MAX, 1));
    directed_rows.push_back(known_row(1, 1, 1, 100, 1, 1, 100, 0, 0));
    directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0, 0, SPEED_MIN, 1));
    directed_rows.push_back(known_row(1, 0, 1, 50, 0, 0, 9950, 0, 0));
    directed_rows.push_back(known_row(0, 0, 1, 9999, 1, 1, 9999, 0, 0));
    directed_rows.push_back(known_row(1, 1, 0, 65535, -1, 0, 65485, 0, 0));
    // Writes to unknown indexes; the gain must still be zero afterwards.
    directed_rows.push_back(write_row(REG_UNUSED, 32'hFFFF_FFFF));
    directed_rows.push_back(write_row(REG_UNUSED_TOP, 32'hFFFF_FFFF));
    directed_rows.push_back(known_row(0, 1, 1, 10000, 0, 0, 1, 0, 0));
    // Largest gain over one microsecond overflows both ways.
    directed_rows.push_back(write_row(REG_SPEED_GAIN, 32'hFFFF_FFFF));
    directed_rows.push_back(write_row(REG_TIMER_MODULUS, 32'h0001_0000));
    directed_rows.push_back(known_row(0, 1, 0, 10001, 1, 1, 1, SPEED_MAX, 1));
    directed_rows.push_back(known_row(0, 0, 0, 10002, 0, 0, 1, SPEED_MIN, 1));
    directed_rows.push_back(known_row(1, 0, 0, 0, 0, 1, 1, SPEED_MAX, 1));
    // A quotient of exactly 2^31 fits backward but not forward.
    directed_rows.push_back(write_row(REG_SPEED_GAIN, 32'h8000_0000));
    directed_rows.push_back(known_row(1, 1, 0, 1, -1, 0, 1, SPEED_MIN, 0));
    directed_rows.push_back(known_row(1, 0, 0, 2, 0, 1, 1, SPEED_MAX, 1));
    directed_rows.push_back(write_row(REG_SPEED_GAIN, 32'h7FFF_FFFF));
    directed_rows.push_back(known_row(0, 0, 1, 10003, 1, 1, 1, SPEED_MAX, 0));
    directed_rows.push_back(edge_row(0, 1, 1, 10005));
    // Moduli at and beyond their limits, written with stray upper bits.
    directed_rows.push_back(write_row(REG_TIMER_MODULUS, 32'h0000_0001));
    directed_rows.push_back(edge_row(0, 1, 0, 0));
    directed_rows.push_back(write_row(REG_TIMER_MODULUS, 32'hFFFF_FFFF));
    directed_rows.push_back(edge_row(1, 1, 1, 0));
    directed_rows.push_back(write_row(REG_TIMER_MODULUS, 32'hFFFE_0000));
    directed_rows.push_back(edge_row(0, 1, 0, 5));
    directed_rows.push_back(edge_row(0, 1, 0, 3));
    directed_rows.push_back(write_row(REG_SPEED_GAIN, 32'h1234_5678));
    directed_rows.push_back(write_row(REG_TIMER_MODULUS, 32'(MODULUS_RESET)));
    directed_rows.push_back(edge_row(1, 0, 1, 9000));
    directed_rows.push_back(edge_row(0, 0, 1, 65535));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        write_register(row.index, row.data);
      end else begin
        send_edge(row.edge_word);
        predicted = meter_step(row.edge_word);
        pending_readings.push_back(row.by_hand ? row.reading : predicted);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          // Back-to-back traffic, no idling on either side.
          gain         = '0;
          modulus_data = 32'(MODULUS_RESET);
          tx_idle      = 1'b0;
          rx_idle      = 1'b0;
        end
        1: begin
          gain         = 32'hFFFF_FFFF;
          modulus_data = 32'h0001_0000;
          tx_idle      = 1'b1;
          rx_idle      = 1'b1;
        end
        PRESSURE_PHASE: begin
          // Sender keeps offering while the receiver is held off below.
          gain         = $urandom;
          modulus_data = 32'(MODULUS_RESET);
          tx_idle      = 1'b0;
          rx_idle      = 1'b1;
        end
        3: begin
          gain         = $urandom_range(0, 65535);
          modulus_data = $urandom_range(1, 65536);
          tx_idle      = 1'b1;
          rx_idle      = 1'b1;
        end
        4: begin
          gain         = $urandom;
          modulus_data = 32'h0000_0001;
          tx_idle      = 1'b1;
          rx_idle      = 1'b0;
        end
        default: begin
          // Any data word, so the modulus may well be out of range.
          gain         = $urandom;
          modulus_data = $urandom;
          tx_idle      = 1'b1;
          rx_idle      = 1'b1;
        end
      endcase
      write_register(REG_SPEED_GAIN, gain);
      write_register(REG_TIMER_MODULUS, modulus_data);
      modulus      = int'(modulus_data[MODULUS_BITS-1:0]);
      modulus_sane = (modulus >= 1 && modulus <= 65536);
      if (modulus_sane) timer_now = timer_now % modulus;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == PRESSURE_PHASE && n == 40) hold_req = 1'b1;
        w.wheel   = $urandom_range(0, 1);
        w.phase_a = $urandom_range(0, 1);
        w.phase_b = $urandom_range(0, 1);
        // Mostly a timer that runs forward and wraps at the modulus, with
        // repeats and tiny steps for zero periods and large speeds, and some
        // stamps anywhere in the field.
        if (!modulus_sane || $urandom_range(0, 9) == 0) begin
          w.stamp_us = $urandom_range(0, 65535);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 6) begin
            step = 0;
          end else if (pick < 55) begin
            step = $urandom_range(1, 100);
          end else if (pick < 85) begin
            step = $urandom_range(101, 5000);
          end else begin
            step = $urandom_range(0, modulus - 1);
          end
          timer_now  = (timer_now + step) % modulus;
          w.stamp_us = timer_now[15:0];
        end
        send_edge(w);
        pending_readings.push_back(meter_step(w));
      end
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    // Any stray word after the last expected one is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
